[rtl/bta_pkg.sv]
package bta_pkg;

  localparam int unsigned DivW    = 33;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned EntryW  = 3;
  localparam int unsigned TotalCfgW = 11;

  localparam logic [EntryW-1:0] FlagTaken = 3'b001;
  localparam logic [EntryW-1:0] FlagFirst = 3'b010;
  localparam logic [EntryW-1:0] FlagNext  = 3'b100;
  localparam logic [7:0]        TypeMask  = 8'h0f;

  localparam logic [TotalCfgW-1:0] BlockTotalReset = 11'd1024;

  typedef enum logic {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  typedef enum logic {
    RegHeapStart  = 1'b0,
    RegBlockTotal = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusNoRun   = 2'd1,
    StatusOutside = 2'd2,
    StatusZero    = 2'd3
  } status_e;

  typedef enum logic [10:0] {
    SClear = 11'b000_0000_0001,
    SIdle  = 11'b000_0000_0010,
    SBase  = 11'b000_0000_0100,
    SSetup = 11'b000_0000_1000,
    SNeed  = 11'b000_0001_0000,
    SScan  = 11'b000_0010_0000,
    SMark  = 11'b000_0100_0000,
    SProd  = 11'b000_1000_0000,
    SAddr  = 11'b001_0000_0000,
    SIdx   = 11'b010_0000_0000,
    SWalk  = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic           done;
    logic [DivW-1:0] quotient;
  } div_res_t;

endpackage

[rtl/bta_ram.sv]
module bta_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/bta_div.sv]
module bta_div #(
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bta_pkg::DivW-1:0]       dividend_i,
  output bta_pkg::div_res_t              res_o,
  output logic [$clog2(BLOCK_BYTES)-1:0] remainder_o
);

  localparam int unsigned RW = $clog2(BLOCK_BYTES);

  logic                     done_q;
  logic [bta_pkg::DivW-1:0] quo_q;
  logic [RW-1:0]            rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // BLOCK_BYTES is a power of two: quotient is a shift, remainder a mask
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i >> RW;
      rem_q <= dividend_i[RW-1:0];
    end
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;
  assign remainder_o    = rem_q;

endmodule

[rtl/block_table_heap_allocator_unit.sv]
// Channel    Direction  Signals                                   Transaction
// input      in         start, busy, opcode_i, size_bytes_i,      start & !busy
//                       free_address_i
// result     out        done_o, result_address_o, status_o        done_o, one cycle
// config     in/out     psel, penable, pwrite, paddr, pwdata,     psel & penable & pwrite
//                       prdata, pready
//
// After reset a clearing pass writes every table entry with busy high.
// A transaction uses the shared shift unit for the heap base, then once more for the block
// count (allocate) or block index (free, unless the address is below the base or the
// table is empty); BLOCK_BYTES is a power of two. Allocate scans and marks one entry per
// cycle, then forms the block offset and result address. Free walks one entry per cycle.
// A zero-size allocate answers the cycle after start. The result strobe cannot be stalled.
module block_table_heap_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned BLOCK_BYTES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [31:0]                    size_bytes_i,
  input  logic [31:0]                    free_address_i,
  output logic                           done_o,
  output logic [31:0]                    result_address_o,
  output logic [1:0]                     status_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bta_pkg::ApbAddrW-1:0]   paddr,
  input  logic [bta_pkg::ApbDataW-1:0]   pwdata,
  output logic [bta_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned TW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (TW > bta_pkg::TotalCfgW) ? TW : bta_pkg::TotalCfgW;
  localparam int unsigned RW = $clog2(BLOCK_BYTES);
  localparam int unsigned PW = AW + 17;
  localparam int unsigned DW = bta_pkg::DivW;

  bta_pkg::state_e  state_q, state_d;
  bta_pkg::op_e     op_q;
  bta_pkg::status_e status_q, status_d;

  logic [31:0]                   heap_start_q;
  logic [bta_pkg::TotalCfgW-1:0] block_total_q;
  logic [TW-1:0]                 total;

  logic [31:0]   size_q, faddr_q;
  logic [31:0]   base_q, base_d;
  logic [DW-1:0] need_q, need_d;
  logic [AW-1:0] chk_q, chk_d;
  logic [TW-1:0] run_q, run_d;
  logic [AW-1:0] first_q, first_d;
  logic [AW-1:0] mark_q, mark_d;
  logic [TW-1:0] left_q, left_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   prod_q, prod_d;
  logic          done_q, done_d;
  logic [31:0]   res_addr_q, res_addr_d;

  logic                      accept;
  logic                      cfg_we;
  logic                      div_start;
  logic [DW-1:0]             dividend;
  bta_pkg::div_res_t         div_res;
  logic [RW-1:0]             div_rem;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [bta_pkg::EntryW-1:0] wdata;
  logic [AW-1:0]             raddr;
  logic [bta_pkg::EntryW-1:0] rdata;
  logic                      taken;

  assign busy   = (state_q != bta_pkg::SIdle);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (bta_pkg::reg_idx_e'(paddr[2]))
      bta_pkg::RegHeapStart:  prdata = heap_start_q;
      bta_pkg::RegBlockTotal: prdata = bta_pkg::ApbDataW'(block_total_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q  <= '0;
      block_total_q <= bta_pkg::BlockTotalReset;
    end else if (cfg_we) begin
      unique case (bta_pkg::reg_idx_e'(paddr[2]))
        bta_pkg::RegHeapStart:  heap_start_q  <= pwdata;
        bta_pkg::RegBlockTotal: block_total_q <= pwdata[bta_pkg::TotalCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign total = (CW'(block_total_q) < CW'(TABLE_DEPTH)) ? TW'(block_total_q)
                                                         : TW'(TABLE_DEPTH);

  bta_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .res_o      (div_res),
    .remainder_o(div_rem)
  );

  bta_ram #(
    .Width(bta_pkg::EntryW),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign taken = (8'(rdata) & bta_pkg::TypeMask & 8'(bta_pkg::FlagTaken)) != 8'd0;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    base_d     = base_q;
    need_d     = need_q;
    chk_d      = chk_q;
    run_d      = run_q;
    first_d    = first_q;
    mark_d     = mark_q;
    left_d     = left_q;
    walk_d     = walk_q;
    clr_d      = clr_q;
    prod_d     = prod_q;
    done_d     = 1'b0;
    res_addr_d = res_addr_q;
    div_start  = 1'b0;
    dividend   = {1'b0, heap_start_q};
    we         = 1'b0;
    waddr      = clr_q;
    wdata      = '0;
    raddr      = '0;

    unique case (state_q)
      bta_pkg::SClear: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = bta_pkg::SIdle;
        end
      end
      bta_pkg::SIdle: begin
        if (accept) begin
          if (bta_pkg::op_e'(opcode_i) == bta_pkg::OpAlloc && size_bytes_i == '0) begin
            done_d     = 1'b1;
            status_d   = bta_pkg::StatusZero;
            res_addr_d = '0;
          end else begin
            div_start = 1'b1;
            state_d   = bta_pkg::SBase;
          end
        end
      end
      bta_pkg::SBase: begin
        if (div_res.done) begin
          base_d  = heap_start_q - 32'(div_rem);
          state_d = bta_pkg::SSetup;
        end
      end
      bta_pkg::SSetup: begin
        if (op_q == bta_pkg::OpAlloc) begin
          div_start = 1'b1;
          dividend  = DW'(size_q) + DW'(BLOCK_BYTES - 1);
          state_d   = bta_pkg::SNeed;
        end else if (faddr_q < base_q || total == '0) begin
          done_d     = 1'b1;
          status_d   = bta_pkg::StatusOutside;
          res_addr_d = '0;
          state_d    = bta_pkg::SIdle;
        end else begin
          div_start = 1'b1;
          dividend  = DW'(faddr_q - base_q);
          state_d   = bta_pkg::SIdx;
        end
      end
      bta_pkg::SNeed: begin
        if (div_res.done) begin
          need_d = div_res.quotient;
          if (total == '0) begin
            done_d     = 1'b1;
            status_d   = bta_pkg::StatusNoRun;
            res_addr_d = '0;
            state_d    = bta_pkg::SIdle;
          end else begin
            raddr   = '0;
            chk_d   = '0;
            run_d   = '0;
            state_d = bta_pkg::SScan;
          end
        end
      end
      bta_pkg::SScan: begin
        raddr = chk_q + 1'b1;
        chk_d = chk_q + 1'b1;
        if (taken) begin
          run_d = '0;
        end else begin
          run_d = run_q + 1'b1;
          if (run_q == '0) begin
            first_d = chk_q;
          end
        end
        if (!taken && (DW'(run_q) + DW'(1)) == need_q) begin
          mark_d  = (run_q == '0) ? chk_q : first_q;
          left_d  = TW'(need_q);
          state_d = bta_pkg::SMark;
        end else if (TW'(chk_q) + TW'(1) == total) begin
          done_d     = 1'b1;
          status_d   = bta_pkg::StatusNoRun;
          res_addr_d = '0;
          state_d    = bta_pkg::SIdle;
        end
      end
      bta_pkg::SMark: begin
        we     = 1'b1;
        waddr  = mark_q;
        wdata  = bta_pkg::FlagTaken
               | ((mark_q == first_q) ? bta_pkg::FlagFirst : '0)
               | ((left_q > TW'(1)) ? bta_pkg::FlagNext : '0);
        mark_d = mark_q + 1'b1;
        left_d = left_q - 1'b1;
        if (left_q == TW'(1)) begin
          state_d = bta_pkg::SProd;
        end
      end
      bta_pkg::SProd: begin
        prod_d  = 32'(PW'(first_q) * PW'(BLOCK_BYTES));
        state_d = bta_pkg::SAddr;
      end
      bta_pkg::SAddr: begin
        done_d     = 1'b1;
        status_d   = bta_pkg::StatusOk;
        res_addr_d = base_q + prod_q;
        state_d    = bta_pkg::SIdle;
      end
      bta_pkg::SIdx: begin
        if (div_res.done) begin
          if (div_res.quotient >= DW'(total)) begin
            done_d     = 1'b1;
            status_d   = bta_pkg::StatusOutside;
            res_addr_d = '0;
            state_d    = bta_pkg::SIdle;
          end else begin
            raddr   = AW'(div_res.quotient);
            walk_d  = AW'(div_res.quotient);
            state_d = bta_pkg::SWalk;
          end
        end
      end
      bta_pkg::SWalk: begin
        we     = 1'b1;
        waddr  = walk_q;
        wdata  = '0;
        raddr  = walk_q + 1'b1;
        walk_d = walk_q + 1'b1;
        if ((rdata & bta_pkg::FlagNext) == '0 || TW'(walk_q) + TW'(1) == total) begin
          done_d     = 1'b1;
          status_d   = bta_pkg::StatusOk;
          res_addr_d = '0;
          state_d    = bta_pkg::SIdle;
        end
      end
      default: begin
        state_d = bta_pkg::SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bta_pkg::SClear;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= bta_pkg::op_e'(opcode_i);
      size_q  <= size_bytes_i;
      faddr_q <= free_address_i;
    end
    status_q   <= status_d;
    base_q     <= base_d;
    need_q     <= need_d;
    chk_q      <= chk_d;
    run_q      <= run_d;
    first_q    <= first_d;
    mark_q     <= mark_d;
    left_q     <= left_d;
    walk_q     <= walk_d;
    prod_q     <= prod_d;
    res_addr_q <= res_addr_d;
  end

  assign done_o           = done_q;
  assign result_address_o = res_addr_q;
  assign status_o         = status_q;

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted transaction neither busy nor answered");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bta_pkg::StatusOk) |-> (result_address_o == '0))
    else $error("failed transaction returns nonzero address");

  a_set_only_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && wdata != '0) |-> (state_q == bta_pkg::SMark))
    else $error("nonzero table write outside run marking");
`endif

endmodule
